// ===== hdl/prs_pkg.sv =====
// Shared types and constants for the periodic report sender.
package prs_pkg;

    // Kind of item on the input channel.
    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_BYTE = 1'b1
    } t_command;

    // Kind of report produced by one item.
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_DATA = 2'd1,
        KIND_FAN  = 2'd2
    } t_send_kind;

    // Received byte codes with a meaning.
    localparam logic [7:0] BYTE_ACK        = 8'h06;
    localparam logic [7:0] BYTE_RESUME     = 8'h72; // 'r'
    localparam logic [7:0] BYTE_RESTART    = 8'h64; // 'd'
    localparam logic [7:0] BYTE_QUIT       = 8'h71; // 'q'
    localparam logic [7:0] BYTE_FAN_ON     = 8'h65; // 'e'
    localparam logic [7:0] BYTE_FAN_OFF    = 8'h61; // 'a'
    localparam logic [7:0] BYTE_FAN_STATUS = 8'h73; // 's'
    localparam logic [7:0] BYTE_INTERVAL_1 = 8'h31; // '1'
    localparam logic [7:0] BYTE_INTERVAL_4 = 8'h34; // '4'

    // Report interval settings in ticks.
    localparam logic [2:0] INTERVAL_SHORT = 3'd1;
    localparam logic [2:0] INTERVAL_LONG  = 3'd4;

    // Largest retry count that the 2-bit counter can hold.
    localparam int unsigned MAX_COUNTED_RETRIES = 3;

    // One input item.
    typedef struct packed {
        t_command           command;
        logic [7:0]         rx_byte;
        logic signed [7:0]  temperature;
        logic [6:0]         humidity;
    } t_item;

    // One result item.
    typedef struct packed {
        t_send_kind         send_kind;
        logic signed [7:0]  report_temperature;
        logic [6:0]         report_humidity;
        logic [7:0]         report_sequence;
        logic               fan_level;
        logic               alarm_level;
    } t_result;

endpackage

// ===== hdl/prs_core.sv =====
// Protocol state of the sender and the combinational logic that handles one item.
module prs_core #(
    parameter logic [1:0] RETRY_CAP = 2'd3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  prs_pkg::t_item   i_item,
    output prs_pkg::t_result o_result
);

    logic [2:0] r_tick, n_tick;
    logic [2:0] r_interval, n_interval;
    logic       r_awaiting, n_awaiting;
    logic [1:0] r_retries, n_retries;
    logic       r_sending, n_sending;
    logic [7:0] r_seq, n_seq;
    logic       r_fan, n_fan;
    logic       r_alarm, n_alarm;

    logic [2:0]          tick_inc;
    prs_pkg::t_send_kind kind;

    // Next state and report kind for the item at the input register.
    always_comb begin
        n_tick     = r_tick;
        n_interval = r_interval;
        n_awaiting = r_awaiting;
        n_retries  = r_retries;
        n_sending  = r_sending;
        n_seq      = r_seq;
        n_fan      = r_fan;
        n_alarm    = r_alarm;
        kind       = prs_pkg::KIND_NONE;
        tick_inc   = r_tick + 3'd1;

        if (i_item.command == prs_pkg::CMD_TICK) begin
            if (r_sending) begin
                if (tick_inc < r_interval) begin
                    n_tick = tick_inc;
                end else begin
                    n_tick = '0;
                    if (!r_awaiting) begin
                        // First transmission of this report.
                        n_awaiting = 1'b1;
                        n_retries  = '0;
                        kind       = prs_pkg::KIND_DATA;
                    end else if (r_retries < RETRY_CAP) begin
                        // No acknowledge yet: send the report again.
                        n_retries = r_retries + 2'd1;
                        kind      = prs_pkg::KIND_DATA;
                    end else begin
                        // Retries used up: stop and raise the alarm.
                        n_sending = 1'b0;
                        n_alarm   = 1'b1;
                    end
                end
            end
        end else begin
            case (i_item.rx_byte)
                prs_pkg::BYTE_ACK: begin
                    n_seq      = r_seq + 8'd1;
                    n_awaiting = 1'b0;
                    n_retries  = '0;
                end
                prs_pkg::BYTE_RESUME: begin
                    n_sending  = 1'b1;
                    n_retries  = '0;
                    n_awaiting = 1'b0;
                    n_alarm    = 1'b0;
                end
                prs_pkg::BYTE_RESTART: begin
                    n_sending  = 1'b1;
                    n_retries  = '0;
                    n_awaiting = 1'b0;
                    n_alarm    = 1'b0;
                    n_tick     = '0;
                end
                prs_pkg::BYTE_QUIT: begin
                    n_sending  = 1'b0;
                    n_retries  = '0;
                    n_awaiting = 1'b0;
                    n_tick     = '0;
                    n_alarm    = 1'b1;
                end
                prs_pkg::BYTE_FAN_ON:     n_fan = 1'b1;
                prs_pkg::BYTE_FAN_OFF:    n_fan = 1'b0;
                prs_pkg::BYTE_FAN_STATUS: kind = prs_pkg::KIND_FAN;
                prs_pkg::BYTE_INTERVAL_1: n_interval = prs_pkg::INTERVAL_SHORT;
                prs_pkg::BYTE_INTERVAL_4: n_interval = prs_pkg::INTERVAL_LONG;
                default: begin
                end
            endcase
        end
    end

    // Result fields; report payload is zero unless a data report goes out.
    always_comb begin
        o_result.send_kind          = kind;
        o_result.report_temperature = '0;
        o_result.report_humidity    = '0;
        o_result.report_sequence    = '0;
        if (kind == prs_pkg::KIND_DATA) begin
            o_result.report_temperature = i_item.temperature;
            o_result.report_humidity    = i_item.humidity;
            o_result.report_sequence    = n_seq;
        end
        o_result.fan_level   = n_fan;
        o_result.alarm_level = n_alarm;
    end

    // State registers update once for each item that moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick     <= '0;
            r_interval <= prs_pkg::INTERVAL_SHORT;
            r_awaiting <= 1'b0;
            r_retries  <= '0;
            r_sending  <= 1'b1;
            r_seq      <= '0;
            r_fan      <= 1'b0;
            r_alarm    <= 1'b0;
        end else if (i_fire) begin
            r_tick     <= n_tick;
            r_interval <= n_interval;
            r_awaiting <= n_awaiting;
            r_retries  <= n_retries;
            r_sending  <= n_sending;
            r_seq      <= n_seq;
            r_fan      <= n_fan;
            r_alarm    <= n_alarm;
        end
    end

endmodule

// ===== hdl/periodic_report_sender_with_ack_retry_unit.sv =====
// Top level of the periodic report sender: input register, core logic, result register.
//
//   Channel | Direction | Handshake                  | Payload
//   --------+-----------+----------------------------+--------------------------------------
//   in      | input     | i_in_valid / o_in_stall    | command, rx_byte, temperature, humidity
//   out     | output    | o_out_valid / i_out_stall  | send_kind, report_*, fan/alarm levels
//
// Each item passes through the input register, then through the core logic into the
// result register, which it leaves once the output transfer completes.
// One item per cycle is sustained while the output side does not stall.
// A stall on the output holds the result register and, once the input register is
// full as well, stalls the input. Reset is synchronous and empties both registers.
module periodic_report_sender_with_ack_retry_unit #(
    parameter int unsigned RETRY_LIMIT = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_command,
    input  logic [7:0]        i_rx_byte,
    input  logic signed [7:0] i_temperature,
    input  logic [6:0]        i_humidity,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [1:0]        o_send_kind,
    output logic signed [7:0] o_report_temperature,
    output logic [6:0]        o_report_humidity,
    output logic [7:0]        o_report_sequence,
    output logic              o_fan_level,
    output logic              o_alarm_level
);

    // Retry count saturates at what the 2-bit counter holds.
    localparam int unsigned EFF_LIMIT = (RETRY_LIMIT > prs_pkg::MAX_COUNTED_RETRIES) ?
                                        prs_pkg::MAX_COUNTED_RETRIES : RETRY_LIMIT;
    localparam logic [1:0]  RETRY_CAP = 2'(EFF_LIMIT);

    logic             r_in_valid;
    prs_pkg::t_item   r_in;
    logic             r_out_valid;
    prs_pkg::t_result r_out;
    prs_pkg::t_result core_result;
    logic             advance;
    logic             in_accept;

    // The held item moves on when the result register is free or being emptied.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in.command     <= prs_pkg::t_command'(i_command);
            r_in.rx_byte     <= i_rx_byte;
            r_in.temperature <= i_temperature;
            r_in.humidity    <= i_humidity;
        end
    end

    prs_core #(
        .RETRY_CAP (RETRY_CAP)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_in),
        .o_result (core_result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_result;
        end
    end

    // Output ports.
    assign o_out_valid          = r_out_valid;
    assign o_send_kind          = r_out.send_kind;
    assign o_report_temperature = r_out.report_temperature;
    assign o_report_humidity    = r_out.report_humidity;
    assign o_report_sequence    = r_out.report_sequence;
    assign o_fan_level          = r_out.fan_level;
    assign o_alarm_level        = r_out.alarm_level;

endmodule

// ===== hdl/prs_checker.sv =====
// Port-level checks for the periodic report sender, bound to its top level.
module prs_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [1:0]        o_send_kind,
    input logic signed [7:0] o_report_temperature,
    input logic [6:0]        o_report_humidity,
    input logic [7:0]        o_report_sequence,
    input logic              o_alarm_level
);

    // A stalled result stays offered, with its kind and sequence number unchanged.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_send_kind)
                                          && $stable(o_report_sequence)))
        else $error("stalled result was dropped or changed");

    // Only the three defined report kinds appear.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_send_kind == prs_pkg::KIND_NONE ||
                         o_send_kind == prs_pkg::KIND_DATA ||
                         o_send_kind == prs_pkg::KIND_FAN))
        else $error("undefined report kind");

    // Report payload is zero unless a data report goes out.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_send_kind != prs_pkg::KIND_DATA) |->
            (o_report_temperature == 8'sd0 && o_report_humidity == 7'd0 &&
             o_report_sequence == 8'd0))
        else $error("payload present without a data report");

    // Sending has stopped whenever the alarm is lit, so no data report then.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_send_kind == prs_pkg::KIND_DATA) |-> !o_alarm_level)
        else $error("data report sent while the alarm is lit");

endmodule

bind periodic_report_sender_with_ack_retry_unit prs_checker u_prs_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .o_out_valid          (o_out_valid),
    .i_out_stall          (i_out_stall),
    .o_send_kind          (o_send_kind),
    .o_report_temperature (o_report_temperature),
    .o_report_humidity    (o_report_humidity),
    .o_report_sequence    (o_report_sequence),
    .o_alarm_level        (o_alarm_level)
);

// ===== verif/testbench.sv =====
// Self-checking testbench for the periodic report sender with acknowledge and retry.
`timescale 1ns / 1ps

// Tracks the sender's state and holds the reports that accepted items should produce.
class report_scoreboard;
    prs_pkg::t_result expected_reports[$];
    int unsigned      mismatches;
    int unsigned      retry_cap;
    logic [2:0]       tick_count;
    logic [2:0]       interval_ticks;
    logic             awaiting_ack;
    logic [1:0]       retries_done;
    logic             sending_on;
    logic [7:0]       seq_number;
    logic             fan_on;
    logic             alarm_on;

    function new(int unsigned retry_limit);
        // The retry counter is only two bits wide, so larger limits saturate.
        retry_cap      = (retry_limit > prs_pkg::MAX_COUNTED_RETRIES) ?
                         prs_pkg::MAX_COUNTED_RETRIES : retry_limit;
        mismatches     = 0;
        tick_count     = 3'd0;
        interval_ticks = prs_pkg::INTERVAL_SHORT;
        awaiting_ack   = 1'b0;
        retries_done   = 2'd0;
        sending_on     = 1'b1;
        seq_number     = 8'd0;
        fan_on         = 1'b0;
        alarm_on       = 1'b0;
    endfunction

    function int unsigned pending();
        return expected_reports.size();
    endfunction

    task flag_mismatch(string msg);
        mismatches++;
        $display("[%0t] error: %s", $time, msg);
    endtask

    // Advances the sender state by one item and returns the report it produces.
    function prs_pkg::t_result predict_report(prs_pkg::t_item it);
        prs_pkg::t_result r;
        r           = '0;
        r.send_kind = prs_pkg::KIND_NONE;
        if (it.command == prs_pkg::CMD_TICK) begin
            if (sending_on) begin
                tick_count = tick_count + 3'd1;
                if (tick_count >= interval_ticks) begin
                    tick_count = 3'd0;
                    if (!awaiting_ack) begin
                        awaiting_ack = 1'b1;
                        retries_done = 2'd0;
                        r.send_kind  = prs_pkg::KIND_DATA;
                    end else if (retries_done < retry_cap) begin
                        retries_done = retries_done + 2'd1;
                        r.send_kind  = prs_pkg::KIND_DATA;
                    end else begin
                        // Out of retries: give up and light the alarm.
                        sending_on = 1'b0;
                        alarm_on   = 1'b1;
                    end
                end
            end
        end else begin
            case (it.rx_byte)
                prs_pkg::BYTE_ACK: begin
                    // Applies whether or not an acknowledge was awaited.
                    seq_number   = seq_number + 8'd1;
                    awaiting_ack = 1'b0;
                    retries_done = 2'd0;
                end
                prs_pkg::BYTE_RESUME, prs_pkg::BYTE_RESTART: begin
                    sending_on   = 1'b1;
                    retries_done = 2'd0;
                    awaiting_ack = 1'b0;
                    alarm_on     = 1'b0;
                    if (it.rx_byte == prs_pkg::BYTE_RESTART) begin
                        tick_count = 3'd0;
                    end
                end
                prs_pkg::BYTE_QUIT: begin
                    sending_on   = 1'b0;
                    retries_done = 2'd0;
                    awaiting_ack = 1'b0;
                    tick_count   = 3'd0;
                    alarm_on     = 1'b1;
                end
                prs_pkg::BYTE_FAN_ON:     fan_on = 1'b1;
                prs_pkg::BYTE_FAN_OFF:    fan_on = 1'b0;
                prs_pkg::BYTE_FAN_STATUS: r.send_kind = prs_pkg::KIND_FAN;
                prs_pkg::BYTE_INTERVAL_1: interval_ticks = prs_pkg::INTERVAL_SHORT;
                prs_pkg::BYTE_INTERVAL_4: interval_ticks = prs_pkg::INTERVAL_LONG;
                default: ;
            endcase
        end
        // Only a data report carries the readings and the sequence number.
        if (r.send_kind == prs_pkg::KIND_DATA) begin
            r.report_temperature = it.temperature;
            r.report_humidity    = it.humidity;
            r.report_sequence    = seq_number;
        end
        r.fan_level   = fan_on;
        r.alarm_level = alarm_on;
        return r;
    endfunction

    function void note_item(prs_pkg::t_item it);
        expected_reports.push_back(predict_report(it));
    endfunction

    // Compares one output transfer with the oldest outstanding report.
    task check_report(prs_pkg::t_result got);
        prs_pkg::t_result want;
        if (expected_reports.size() == 0) begin
            flag_mismatch("report transfer arrived with nothing outstanding");
            return;
        end
        want = expected_reports.pop_front();
        if (got.send_kind !== want.send_kind) begin
            flag_mismatch($sformatf("send_kind got %0d, expected %0d",
                                    got.send_kind, want.send_kind));
        end
        if (got.report_temperature !== want.report_temperature) begin
            flag_mismatch($sformatf("report_temperature got %0d, expected %0d",
                                    got.report_temperature, want.report_temperature));
        end
        if (got.report_humidity !== want.report_humidity) begin
            flag_mismatch($sformatf("report_humidity got %0d, expected %0d",
                                    got.report_humidity, want.report_humidity));
        end
        if (got.report_sequence !== want.report_sequence) begin
            flag_mismatch($sformatf("report_sequence got %0d, expected %0d",
                                    got.report_sequence, want.report_sequence));
        end
        if (got.fan_level !== want.fan_level) begin
            flag_mismatch($sformatf("fan_level got %0b, expected %0b",
                                    got.fan_level, want.fan_level));
        end
        if (got.alarm_level !== want.alarm_level) begin
            flag_mismatch($sformatf("alarm_level got %0b, expected %0b",
                                    got.alarm_level, want.alarm_level));
        end
    endtask
endclass

module testbench;
    localparam int unsigned RETRY_LIMIT  = 3;
    localparam int unsigned LONG_HOLD    = 48;
    localparam int unsigned TAIL_CYCLES  = 10;
    localparam int unsigned TIMEOUT_NS   = 2_000_000;

    logic              i_clk                = 1'b0;
    logic              i_rst_n              = 1'b0;
    logic              i_in_valid           = 1'b0;
    logic              o_in_stall;
    logic              i_command            = 1'b0;
    logic [7:0]        i_rx_byte            = 8'd0;
    logic signed [7:0] i_temperature        = 8'sd0;
    logic [6:0]        i_humidity           = 7'd0;
    logic              o_out_valid;
    logic              i_out_stall          = 1'b0;
    logic [1:0]        o_send_kind;
    logic signed [7:0] o_report_temperature;
    logic [6:0]        o_report_humidity;
    logic [7:0]        o_report_sequence;
    logic              o_fan_level;
    logic              o_alarm_level;

    int unsigned       send_idle_pct = 0;
    int unsigned       recv_idle_pct = 0;
    logic              hold_req      = 1'b0;
    int unsigned       hold_count    = 0;
    report_scoreboard  sb;

    periodic_report_sender_with_ack_retry_unit #(
        .RETRY_LIMIT(RETRY_LIMIT)
    ) i_dut (.*);

    always #2 i_clk = ~i_clk;

    // Receiver: one long hold-off when asked, otherwise random stalls.
    always @(posedge i_clk) begin
        if (hold_req && hold_count < LONG_HOLD) begin
            i_out_stall <= 1'b1;
            hold_count  <= hold_count + 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Note every accepted input transfer and check every accepted output transfer.
    always @(posedge i_clk) begin
        prs_pkg::t_item   seen;
        prs_pkg::t_result got;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            seen.command     = prs_pkg::t_command'(i_command);
            seen.rx_byte     = i_rx_byte;
            seen.temperature = i_temperature;
            seen.humidity    = i_humidity;
            sb.note_item(seen);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.send_kind          = prs_pkg::t_send_kind'(o_send_kind);
            got.report_temperature = o_report_temperature;
            got.report_humidity    = o_report_humidity;
            got.report_sequence    = o_report_sequence;
            got.fan_level          = o_fan_level;
            got.alarm_level        = o_alarm_level;
            sb.check_report(got);
        end
    end

    // Offers one item, with random idle cycles first, and waits for its transfer.
    task automatic send_item(input prs_pkg::t_command cmd, input logic [7:0] rx,
                             input logic signed [7:0] temp, input logic [6:0] hum);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_command     <= cmd;
        i_rx_byte     <= rx;
        i_temperature <= temp;
        i_humidity    <= hum;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic send_tick();
        send_item(prs_pkg::CMD_TICK, 8'($urandom), 8'($urandom), 7'($urandom));
    endtask

    task automatic send_byte(input logic [7:0] rx);
        send_item(prs_pkg::CMD_BYTE, rx, 8'($urandom), 7'($urandom));
    endtask

    // Stops offering items until every outstanding report has arrived.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Mostly ticks and acknowledges, so reports, retries and the alarm all come round,
    // with commands sprinkled in and some arbitrary bytes as noise.
    task automatic run_random(input int unsigned count);
        int unsigned roll;
        logic [7:0]  rx;
        for (int unsigned n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            if (roll < 55) begin
                send_tick();
            end else begin
                if (roll < 70) begin
                    rx = prs_pkg::BYTE_ACK;
                end else if (roll < 80) begin
                    rx = ($urandom_range(1) != 0) ? prs_pkg::BYTE_RESUME
                                                  : prs_pkg::BYTE_RESTART;
                end else if (roll < 90) begin
                    case ($urandom_range(5))
                        0:       rx = prs_pkg::BYTE_QUIT;
                        1:       rx = prs_pkg::BYTE_FAN_ON;
                        2:       rx = prs_pkg::BYTE_FAN_OFF;
                        3:       rx = prs_pkg::BYTE_FAN_STATUS;
                        4:       rx = prs_pkg::BYTE_INTERVAL_1;
                        default: rx = prs_pkg::BYTE_INTERVAL_4;
                    endcase
                end else begin
                    rx = 8'($urandom);
                end
                send_byte(rx);
            end
        end
    endtask

    // Main sequence: reset, directed items, then three random phases.
    initial begin
        sb = new(RETRY_LIMIT);
        repeat (12) @(posedge i_clk);
        i_rst_n       <= 1'b1;
        send_idle_pct = 37;
        recv_idle_pct = 84;

        // First report with the lowest readings, acknowledged, then the highest readings.
        send_item(prs_pkg::CMD_TICK, 8'h00, 8'sh80, 7'd0);
        send_byte(prs_pkg::BYTE_ACK);
        send_item(prs_pkg::CMD_TICK, 8'hff, 8'sh7f, 7'd127);
        // Three retries, then sending gives up and the alarm lights.
        repeat (4) send_tick();
        send_tick();
        send_byte(prs_pkg::BYTE_RESUME);
        // Long interval: the fourth tick sends.
        send_byte(prs_pkg::BYTE_INTERVAL_4);
        repeat (4) send_tick();
        // Fan control and fan status reports.
        send_byte(prs_pkg::BYTE_FAN_ON);
        send_byte(prs_pkg::BYTE_FAN_STATUS);
        send_byte(prs_pkg::BYTE_FAN_OFF);
        send_byte(prs_pkg::BYTE_FAN_STATUS);
        // Quit, a tick while stopped, restart, short interval.
        send_byte(prs_pkg::BYTE_QUIT);
        send_tick();
        send_byte(prs_pkg::BYTE_RESTART);
        send_byte(prs_pkg::BYTE_INTERVAL_1);
        // Bytes without meaning, and an acknowledge that nobody awaits.
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(prs_pkg::BYTE_ACK);
        drain();

        run_random(500);
        drain();

        send_idle_pct = 84;
        recv_idle_pct = 37;
        run_random(500);
        drain();

        // No idling; the receiver's long hold-off fills the block and stalls the input.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      <= 1'b1;
        run_random(500);
        drain();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #(TIMEOUT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/prs_pkg.sv
hdl/prs_core.sv
hdl/periodic_report_sender_with_ack_retry_unit.sv
hdl/prs_checker.sv
verif/testbench.sv
